// ----- rtl/core/prap_pkg.sv -----
// ----------------------------------------------------------------------------
// prap_pkg: shared types and constants for the point rotation unit
// Holds fixed-point widths, the CORDIC arctangent table in binary-angle
// units, the gain compensation constant and the side-band struct.
// ----------------------------------------------------------------------------
`default_nettype none

package prap_pkg;

    // Default iteration count and the largest count that the table supports
    localparam int unsigned CORDIC_STEPS_DEF = 24;
    localparam int unsigned ATAN_ENTRIES     = 31;

    // Coordinate width on the ports (signed Q16.16)
    localparam int unsigned DW = 32;
    // CORDIC datapath width: 33-bit difference, negation and CORDIC growth
    localparam int unsigned CW = 36;
    // Angle residue width
    localparam int unsigned ZW = 34;

    // Gain compensation 1/K of the infinite CORDIC in Q1.30
    localparam int unsigned KW = 31;
    localparam logic signed [KW-1:0] GAIN_Q30 = 31'sd652032874;

    // Gain multiply split: low part unsigned, high part signed
    localparam int unsigned LOW_W  = 18;
    localparam int unsigned HIGH_W = CW - LOW_W;
    localparam int unsigned PLO_W  = LOW_W + KW - 1;
    localparam int unsigned PHI_W  = HIGH_W + KW;
    localparam int unsigned SUM_W  = PHI_W + LOW_W;
    localparam int unsigned GAIN_SHIFT = 30;

    // Quadrant fold limits in binary-angle units
    localparam logic signed [DW-1:0] ANG_QUARTER     = 32'sd1073741824;
    localparam logic signed [DW-1:0] ANG_NEG_QUARTER = -32'sd1073741824;
    localparam logic signed [ZW-1:0] ANG_HALF        = 34'sd2147483648;

    // Saturation limits
    localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;

    // Plane select codes
    localparam logic PLANE_XY = 1'b0;
    localparam logic PLANE_YZ = 1'b1;

    // atan(2^-i) scaled so that a full turn is 2^32, rounded
    localparam logic [DW-1:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1
    };

    // Values that ride along the pipeline next to the CORDIC pair
    typedef struct packed {
        logic                 plane;
        logic signed [DW-1:0] pass;
        logic signed [DW-1:0] piv_a;
        logic signed [DW-1:0] piv_b;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_rotate_about_pivot_unit.sv -----
// ----------------------------------------------------------------------------
// point_rotate_about_pivot_unit: rotate a 3D point about a pivot in one plane
// Subtracts the pivot, rotates the selected pair with a pipelined,
// gain-compensated CORDIC, adds the pivot back and saturates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a point, a pivot, a binary
//   angle (2^32 per turn) and a plane select (0: x,y  1: y,z). Output
//   channel (out_valid / out_stall) returns the rotated point and an
//   overflow flag that is set when a rotated coordinate was clamped.
//   One transaction in gives exactly one transaction out, in order.
//   Each transaction passes through the input stage, one stage per CORDIC
//   iteration, two gain-multiply stages and the pivot add / saturate stage.
//   Throughput is one transaction per cycle while the output is not held by
//   out_stall; each CORDIC iteration owns its own adder stage.
//   When the output holds a result and out_stall is high the whole pipeline
//   freezes and in_stall is raised in the same cycle; nothing is dropped or
//   repeated. Reset clears all valid bits; no output is valid after reset
//   and the block accepts input in the first cycle after reset release.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_about_pivot_unit
    import prap_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic signed [DW-1:0] point_x,
    input  wire logic signed [DW-1:0] point_y,
    input  wire logic signed [DW-1:0] point_z,
    input  wire logic signed [DW-1:0] pivot_x,
    input  wire logic signed [DW-1:0] pivot_y,
    input  wire logic signed [DW-1:0] pivot_z,
    input  wire logic        [DW-1:0] angle,
    input  wire logic                 plane,

    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic signed [DW-1:0] out_x,
    output      logic signed [DW-1:0] out_y,
    output      logic signed [DW-1:0] out_z,
    output      logic                 overflow
);

    // ------------------------------------------------------------------
    // Pipeline enable: freeze everything while the result is held
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage arrays: entry 0 is the input stage, entry i+1 follows iteration i
    logic                 vld_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg    [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg    [0:CORDIC_STEPS];
    side_t                side_reg [0:CORDIC_STEPS];

    // ------------------------------------------------------------------
    // Input stage: form differences, negate the angle, fold the quadrant
    // ------------------------------------------------------------------
    logic signed [CW-1:0] a_diff, b_diff;
    logic signed [DW-1:0] theta;
    logic signed [ZW-1:0] theta_ext;
    logic signed [CW-1:0] x0_next, y0_next;
    logic signed [ZW-1:0] z0_next;
    side_t                side0_next;

    always_comb
    begin
        if (plane == PLANE_XY)
        begin
            a_diff           = CW'(point_x) - CW'(pivot_x);
            b_diff           = CW'(point_y) - CW'(pivot_y);
            side0_next.pass  = point_z;
            side0_next.piv_a = pivot_x;
            side0_next.piv_b = pivot_y;
        end
        else
        begin
            a_diff           = CW'(point_y) - CW'(pivot_y);
            b_diff           = CW'(point_z) - CW'(pivot_z);
            side0_next.pass  = point_x;
            side0_next.piv_a = pivot_y;
            side0_next.piv_b = pivot_z;
        end
        side0_next.plane = plane;

        theta     = $signed(DW'(0) - angle);
        theta_ext = ZW'(theta);

        if (theta > ANG_QUARTER)
        begin
            x0_next = -a_diff;
            y0_next = -b_diff;
            z0_next = theta_ext - ANG_HALF;
        end
        else if (theta < ANG_NEG_QUARTER)
        begin
            x0_next = -a_diff;
            y0_next = -b_diff;
            z0_next = theta_ext + ANG_HALF;
        end
        else
        begin
            x0_next = a_diff;
            y0_next = b_diff;
            z0_next = theta_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            side_reg[0] <= side0_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC iterations, one register stage each
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] dz;
        logic signed [CW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign dz = $signed({{(ZW-DW){1'b0}}, ATAN_TURNS[i]});

        always_comb
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - dz;
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + dz;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Gain multiply, first stage: partial products of each coordinate
    // ------------------------------------------------------------------
    logic                    m1_vld_reg;
    logic        [PLO_W-1:0] xlo_reg, ylo_reg;
    logic signed [PHI_W-1:0] xhi_reg, yhi_reg;
    side_t                   m1_side_reg;

    logic        [PLO_W-1:0] xlo_next, ylo_next;
    logic signed [PHI_W-1:0] xhi_next, yhi_next;

    always_comb
    begin
        xlo_next = PLO_W'(x_reg[CORDIC_STEPS][LOW_W-1:0]) * PLO_W'($unsigned(GAIN_Q30));
        ylo_next = PLO_W'(y_reg[CORDIC_STEPS][LOW_W-1:0]) * PLO_W'($unsigned(GAIN_Q30));
        xhi_next = PHI_W'($signed(x_reg[CORDIC_STEPS][CW-1:LOW_W])) * PHI_W'(GAIN_Q30);
        yhi_next = PHI_W'($signed(y_reg[CORDIC_STEPS][CW-1:LOW_W])) * PHI_W'(GAIN_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xlo_reg     <= xlo_next;
            ylo_reg     <= ylo_next;
            xhi_reg     <= xhi_next;
            yhi_reg     <= yhi_next;
            m1_side_reg <= side_reg[CORDIC_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // Gain multiply, second stage: combine, round, shift by 30
    // ------------------------------------------------------------------
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (GAIN_SHIFT - 1);

    logic                    m2_vld_reg;
    logic signed [CW-1:0]    ra_reg, rb_reg;
    side_t                   m2_side_reg;

    logic signed [SUM_W-1:0] xsum, ysum;

    always_comb
    begin
        xsum = $signed({xhi_reg, {LOW_W{1'b0}}})
             + $signed({{(SUM_W-PLO_W){1'b0}}, xlo_reg}) + ROUND_HALF;
        ysum = $signed({yhi_reg, {LOW_W{1'b0}}})
             + $signed({{(SUM_W-PLO_W){1'b0}}, ylo_reg}) + ROUND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_reg      <= xsum[GAIN_SHIFT +: CW];
            rb_reg      <= ysum[GAIN_SHIFT +: CW];
            m2_side_reg <= m1_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add the pivot back, saturate, place coordinates
    // ------------------------------------------------------------------
    logic signed [CW:0]   sum_a, sum_b;
    logic signed [DW-1:0] sat_a, sat_b;
    logic                 ovf_a, ovf_b;

    logic signed [DW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                 overflow_reg;
    logic signed [DW-1:0] out_x_next, out_y_next, out_z_next;
    logic                 overflow_next;

    always_comb
    begin
        sum_a = (CW+1)'(m2_side_reg.piv_a) + (CW+1)'(ra_reg);
        sum_b = (CW+1)'(m2_side_reg.piv_b) + (CW+1)'(rb_reg);

        ovf_a = 1'b0;
        if (sum_a > (CW+1)'(S32_MAX))
        begin
            sat_a = S32_MAX;
            ovf_a = 1'b1;
        end
        else if (sum_a < (CW+1)'(S32_MIN))
        begin
            sat_a = S32_MIN;
            ovf_a = 1'b1;
        end
        else
        begin
            sat_a = sum_a[DW-1:0];
        end

        ovf_b = 1'b0;
        if (sum_b > (CW+1)'(S32_MAX))
        begin
            sat_b = S32_MAX;
            ovf_b = 1'b1;
        end
        else if (sum_b < (CW+1)'(S32_MIN))
        begin
            sat_b = S32_MIN;
            ovf_b = 1'b1;
        end
        else
        begin
            sat_b = sum_b[DW-1:0];
        end

        if (m2_side_reg.plane == PLANE_XY)
        begin
            out_x_next = sat_a;
            out_y_next = sat_b;
            out_z_next = m2_side_reg.pass;
        end
        else
        begin
            out_x_next = m2_side_reg.pass;
            out_y_next = sat_a;
            out_z_next = sat_b;
        end
        overflow_next = ovf_a | ovf_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_z_reg    <= out_z_next;
            overflow_reg <= overflow_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign overflow  = overflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // Folded residue stays within a quarter turn
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (z_reg[0] <= ZW'(ANG_QUARTER)) && (z_reg[0] >= ZW'(ANG_NEG_QUARTER)))
        else $error("CORDIC residue out of range after quadrant fold");

    // A flagged overflow shows a clamped coordinate
    a_ovf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (out_x == S32_MAX) || (out_x == S32_MIN) ||
                                  (out_y == S32_MAX) || (out_y == S32_MIN) ||
                                  (out_z == S32_MAX) || (out_z == S32_MIN))
        else $error("overflow set without a saturated coordinate");

    // A new result only comes from a valid rounding stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(m2_vld_reg))
        else $error("output valid without a transaction in the last stage");
`endif

endmodule

`default_nettype wire
